// File: hw/rtl/bole_pkg.sv
// Shared types and constants of the bounded ordered list engine.
`default_nettype none

package bole_pkg;

  // Command codes carried in the low bits of the input tdata.
  typedef enum logic [3:0] {
    CMD_HEAD_INS = 4'd0,
    CMD_TAIL_INS = 4'd1,
    CMD_INS_AT   = 4'd2,
    CMD_DEL_AT   = 4'd3,
    CMD_GET_AT   = 4'd4,
    CMD_LOCATE   = 4'd5,
    CMD_PRIOR    = 4'd6,
    CMD_NEXT     = 4'd7,
    CMD_CLEAR    = 4'd8,
    CMD_TRAVERSE = 4'd9
  } cmd_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_SHIFT,
    S_INS_PUT,
    S_FETCH_RD,
    S_FETCH_DATA,
    S_DEL_RD,
    S_DEL_WR,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_TRV_RD,
    S_TRV_OUT,
    S_RESULT
  } state_t;

  // Control of one result item handed from the sequencer to the output register.
  typedef struct packed {
    logic valid;
    logic ok;
    logic last;
  } emit_t;

  // Field widths of the stream payloads.
  localparam int CMD_W      = 4;
  localparam int POS_W      = 5;
  localparam int VALUE_W    = 32;
  localparam int FPOS_W     = 4;
  localparam int LEN_W      = 5;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - FPOS_W - LEN_W;

endpackage

`default_nettype wire

// File: hw/rtl/bole_store.sv
// Element memory: one write port and one registered read port.
`default_nettype none

module bole_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bole_ctrl.sv
// Command sequencer with the shared pointer and compare unit of the list engine.
`default_nettype none

module bole_ctrl #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Command side
  input  wire logic                          start_valid,
  output logic                               start_ready,
  input  wire logic [bole_pkg::CMD_W-1:0]    command,
  input  wire logic [bole_pkg::POS_W-1:0]    position,
  input  wire logic [DATA_WIDTH-1:0]         value,
  // Memory side
  output logic                               rd_en,
  output logic [$clog2(CAPACITY)-1:0]        rd_addr,
  output logic                               wr_en,
  output logic [$clog2(CAPACITY)-1:0]        wr_addr,
  output logic [DATA_WIDTH-1:0]              wr_data,
  input  wire logic [DATA_WIDTH-1:0]         rd_data,
  // Result side
  output bole_pkg::emit_t                    emit,
  input  wire logic                          emit_ready,
  output logic [DATA_WIDTH-1:0]              emit_value,
  output logic [$clog2(CAPACITY+1)-1:0]      emit_fpos,
  output logic [$clog2(CAPACITY+1)-1:0]      emit_len
);

  import bole_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  state_t          state;
  state_t          state_next;
  cmd_t            cmd;
  cmd_t            cmd_in;
  logic [CW-1:0]   count;
  logic [CW-1:0]   ptr;
  logic [CW-1:0]   targ;
  logic [DATA_WIDTH-1:0] key;
  logic [DATA_WIDTH-1:0] prev;
  logic            res_ok;
  logic [DATA_WIDTH-1:0] res_value;
  logic [CW-1:0]   res_fpos;

  logic            start;
  logic [PW-1:0]   pos_ext;
  logic [PW-1:0]   cnt_ext;
  logic [PW-1:0]   ins_p;
  logic            full;
  logic            ins_ok;
  logic            pos_ok;
  logic [CW-1:0]   ptr_inc;
  logic [CW-1:0]   ptr_dec;
  logic            ptr_more;
  logic            ptr_above;
  logic            hit;

  // Shared pointer unit and compares.
  assign start_ready = (state == S_IDLE);
  assign start       = start_valid && start_ready;
  assign cmd_in      = cmd_t'(command);
  assign pos_ext     = PW'(position);
  assign cnt_ext     = PW'(count);
  assign full        = (count == CW'(CAPACITY));
  assign pos_ok      = (pos_ext < cnt_ext);
  assign ptr_inc     = ptr + 1'b1;
  assign ptr_dec     = ptr - 1'b1;
  assign ptr_more    = (ptr_inc < count);
  assign ptr_above   = (ptr > targ);
  assign hit         = (rd_data == key);

  // Insert position for the three insert commands.
  always_comb begin
    case (cmd_in)
      CMD_HEAD_INS: ins_p = '0;
      CMD_TAIL_INS: ins_p = cnt_ext;
      default:      ins_p = pos_ext;
    endcase
  end

  assign ins_ok = !full && (ins_p <= cnt_ext);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (cmd_in)
            CMD_HEAD_INS, CMD_TAIL_INS, CMD_INS_AT:
              state_next = ins_ok ? S_INS_RD : S_RESULT;
            CMD_DEL_AT, CMD_GET_AT:
              state_next = pos_ok ? S_FETCH_RD : S_RESULT;
            CMD_LOCATE, CMD_PRIOR, CMD_NEXT, CMD_TRAVERSE: begin
              if (count == '0) begin
                state_next = S_RESULT;
              end else if (cmd_in == CMD_TRAVERSE) begin
                state_next = S_TRV_RD;
              end else begin
                state_next = S_SCAN_RD;
              end
            end
            default: state_next = S_RESULT;
          endcase
        end
      end
      S_INS_RD:     state_next = ptr_above ? S_INS_SHIFT : S_INS_PUT;
      S_INS_SHIFT:  state_next = S_INS_RD;
      S_INS_PUT:    state_next = S_RESULT;
      S_FETCH_RD:   state_next = S_FETCH_DATA;
      S_FETCH_DATA: state_next = (cmd == CMD_DEL_AT) ? S_DEL_RD : S_RESULT;
      S_DEL_RD:     state_next = ptr_more ? S_DEL_WR : S_RESULT;
      S_DEL_WR:     state_next = S_DEL_RD;
      S_SCAN_RD:    state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (hit) begin
          state_next = (cmd == CMD_NEXT && ptr_more) ? S_FETCH_RD : S_RESULT;
        end else begin
          state_next = ptr_more ? S_SCAN_RD : S_RESULT;
        end
      end
      S_TRV_RD:     state_next = S_TRV_OUT;
      S_TRV_OUT: begin
        if (emit_ready) begin
          state_next = ptr_more ? S_TRV_RD : S_IDLE;
        end
      end
      S_RESULT: begin
        if (emit_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory requests and result presentation.
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = ptr[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = ptr[AW-1:0];
    wr_data    = rd_data;
    emit       = '0;
    emit_value = res_value;
    emit_fpos  = res_fpos;
    case (state)
      S_INS_RD: begin
        rd_en   = ptr_above;
        rd_addr = ptr_dec[AW-1:0];
      end
      S_INS_SHIFT: wr_en = 1'b1;
      S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = targ[AW-1:0];
        wr_data = key;
      end
      S_FETCH_RD, S_SCAN_RD, S_TRV_RD: rd_en = 1'b1;
      S_DEL_RD: begin
        rd_en   = ptr_more;
        rd_addr = ptr_inc[AW-1:0];
      end
      S_DEL_WR: wr_en = 1'b1;
      S_TRV_OUT: begin
        emit.valid = 1'b1;
        emit.ok    = 1'b1;
        emit.last  = !ptr_more;
        emit_value = rd_data;
        emit_fpos  = '0;
      end
      S_RESULT: begin
        emit.valid = 1'b1;
        emit.ok    = res_ok;
        emit.last  = 1'b1;
      end
      default: ;
    endcase
  end

  assign emit_len = count;

  // State, length count and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd       <= cmd_in;
            key       <= value;
            res_ok    <= 1'b0;
            res_value <= '0;
            res_fpos  <= '0;
            ptr       <= '0;
            case (cmd_in)
              CMD_HEAD_INS, CMD_TAIL_INS, CMD_INS_AT: begin
                targ <= CW'(ins_p);
                ptr  <= count;
              end
              CMD_DEL_AT, CMD_GET_AT: ptr <= CW'(pos_ext);
              CMD_CLEAR: begin
                count  <= '0;
                res_ok <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_INS_SHIFT: ptr <= ptr_dec;
        S_INS_PUT: begin
          count  <= count + 1'b1;
          res_ok <= 1'b1;
        end
        S_FETCH_DATA: begin
          res_value <= rd_data;
          if (cmd != CMD_DEL_AT) begin
            res_ok <= 1'b1;
          end
        end
        S_DEL_RD: begin
          if (!ptr_more) begin
            count  <= count - 1'b1;
            res_ok <= 1'b1;
          end
        end
        S_DEL_WR: ptr <= ptr_inc;
        S_SCAN_CMP: begin
          if (hit) begin
            case (cmd)
              CMD_LOCATE: begin
                res_ok   <= 1'b1;
                res_fpos <= ptr;
              end
              CMD_PRIOR: begin
                if (ptr != '0) begin
                  res_ok    <= 1'b1;
                  res_value <= prev;
                end
              end
              CMD_NEXT: begin
                if (ptr_more) begin
                  ptr <= ptr_inc;
                end
              end
              default: ;
            endcase
          end else begin
            prev <= rd_data;
            if (ptr_more) begin
              ptr <= ptr_inc;
            end
          end
        end
        S_TRV_OUT: begin
          if (emit_ready && ptr_more) begin
            ptr <= ptr_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // The length never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list length beyond capacity");

  // The length moves by one element at a time or drops to zero on clear.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      (count == CW'($past(count) + 1'b1)) || (count == CW'($past(count) - 1'b1)) ||
      (count == '0))
    else $error("list length jumped");

  // An idle sequencer without a new command leaves the length alone.
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !start_valid) |=> $stable(count))
    else $error("list length changed while idle");

  // Memory is never read and written in the same cycle.
  a_one_port: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && wr_en))
    else $error("memory read and write collide");

endmodule

`default_nettype wire

// File: hw/rtl/bounded_ordered_list_engine_top.sv
// Top level of the bounded ordered list engine: stream ports and output register.
// Insert at position p shifts each element from p to the tail up by one, delete shifts
// each element behind pos down by one, get is a single fetch, a search visits elements
// in order (successor fetches one more), clear only resets the length, and each command
// ends with an output step. Traverse reads each element, then presents it and holds
// until the output register takes it; all steps go through the one element memory.
// A new command is taken only while the sequencer is idle; throughput is one command per run.
// Reset empties the list at once; element storage is not cleared and needs no sweep.
`default_nettype none

module bounded_ordered_list_engine_top #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Command stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // command [3:0], position [8:4], value [40:9], zero [47:41]
  input  wire logic [bole_pkg::IN_TDATA_W-1:0]     s_tdata,
  // Result stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // result_value [31:0], found_position [35:32], list_length [40:36], zero [47:41]
  output logic [bole_pkg::OUT_TDATA_W-1:0]         m_tdata,
  // ok [0]
  output logic                                     m_tuser,
  output logic                                     m_tlast
);

  import bole_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CMD_W-1:0]      in_command;
  logic [POS_W-1:0]      in_position;
  logic [VALUE_W-1:0]    in_value;
  logic [DATA_WIDTH-1:0] key;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;

  emit_t                 emit;
  logic                  emit_ready;
  logic [DATA_WIDTH-1:0] emit_value;
  logic [CW-1:0]         emit_fpos;
  logic [CW-1:0]         emit_len;

  // Unpack the command item; the word is taken as its low DATA_WIDTH bits.
  assign in_command  = s_tdata[CMD_W-1:0];
  assign in_position = s_tdata[CMD_W+POS_W-1:CMD_W];
  assign in_value    = s_tdata[CMD_W+POS_W+VALUE_W-1:CMD_W+POS_W];
  assign key         = DATA_WIDTH'(in_value);

  bole_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start_valid (s_tvalid),
    .start_ready (s_tready),
    .command     (in_command),
    .position    (in_position),
    .value       (key),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_data     (rd_data),
    .emit        (emit),
    .emit_ready  (emit_ready),
    .emit_value  (emit_value),
    .emit_fpos   (emit_fpos),
    .emit_len    (emit_len)
  );

  bole_store #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Output register: loads when empty or when its item is being taken.
  assign emit_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit.valid && emit_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (emit.valid && emit_ready) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, LEN_W'(emit_len), FPOS_W'(emit_fpos),
                  VALUE_W'(emit_value)};
      m_tuser <= emit.ok;
      m_tlast <= emit.last;
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_bounded_ordered_list_engine_top.sv
// Self-checking testbench for the bounded ordered list engine with a built-in list predictor.
`timescale 1ns / 100ps

module tb_bounded_ordered_list_engine_top;
  import bole_pkg::*;

  localparam int LIST_CAP = 16;
  localparam int RANDOM_ITEMS = 420;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS = 10;

  // Command codes the block does not define; they must be rejected.
  localparam logic [3:0] CMD_UNUSED_FIRST = 4'd10;
  localparam logic [3:0] CMD_UNUSED_LAST  = 4'd15;

  // One command item as it travels on the input stream.
  typedef struct {
    logic [3:0]  cmd;
    logic [4:0]  pos;
    logic [31:0] val;
  } cmd_item_t;

  // One result item as the list should report it.
  typedef struct packed {
    logic        ok;
    logic [31:0] value;
    logic [3:0]  fpos;
    logic [4:0]  len;
    logic        last;
  } list_result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  // Predictor state: the list contents and its length.
  logic [31:0] list_words [LIST_CAP];
  int list_len;

  cmd_item_t cmd_queue[$];
  list_result_t pending_results[$];
  cmd_item_t drv_item;
  logic [31:0] val_pool [8];

  int errors;
  int cycles;
  int in_gap;
  int out_stall;
  bit in_quiet;
  bit out_quiet;
  bit in_taken;

  bounded_ordered_list_engine_top #(
    .CAPACITY(LIST_CAP),
    .DATA_WIDTH(32)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Gap lengths: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Apply one accepted command to the predicted list and queue its results.
  task automatic list_apply(input cmd_item_t it);
    list_result_t r;
    int slot;
    int f;
    int i;
    r = '{ok: 1'b0, value: 32'd0, fpos: 4'd0, len: 5'd0, last: 1'b1};
    case (it.cmd)
      CMD_HEAD_INS, CMD_TAIL_INS, CMD_INS_AT: begin
        if (it.cmd == CMD_HEAD_INS) slot = 0;
        else if (it.cmd == CMD_TAIL_INS) slot = list_len;
        else slot = int'(it.pos);
        if (list_len < LIST_CAP && slot <= list_len) begin
          for (i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
          list_words[slot] = it.val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      CMD_DEL_AT: begin
        if (int'(it.pos) < list_len) begin
          r.value = list_words[it.pos];
          for (i = int'(it.pos); i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          r.ok = 1'b1;
        end
      end
      CMD_GET_AT: begin
        if (int'(it.pos) < list_len) begin
          r.value = list_words[it.pos];
          r.ok = 1'b1;
        end
      end
      CMD_LOCATE, CMD_PRIOR, CMD_NEXT: begin
        f = 0;
        while (f < list_len && list_words[f] != it.val) f++;
        if (it.cmd == CMD_LOCATE && f < list_len) begin
          r.ok = 1'b1;
          r.fpos = f[3:0];
        end else if (it.cmd == CMD_PRIOR && f < list_len && f > 0) begin
          r.ok = 1'b1;
          r.value = list_words[f-1];
        end else if (it.cmd == CMD_NEXT && f + 1 < list_len) begin
          r.ok = 1'b1;
          r.value = list_words[f+1];
        end
      end
      CMD_CLEAR: begin
        list_len = 0;
        r.ok = 1'b1;
      end
      CMD_TRAVERSE: begin
        // A non-empty list is emitted element by element, last flag on the tail.
        for (i = 0; i < list_len; i++) begin
          r.ok = 1'b1;
          r.value = list_words[i];
          r.len = list_len[4:0];
          r.last = (i + 1 == list_len);
          pending_results.push_back(r);
        end
      end
      default: ;
    endcase
    r.len = list_len[4:0];
    if (!(it.cmd == CMD_TRAVERSE && list_len > 0)) pending_results.push_back(r);
  endtask

  task automatic add_cmd(input logic [3:0] cmd, input logic [4:0] pos, input logic [31:0] val);
    cmd_item_t it;
    it.cmd = cmd;
    it.pos = pos;
    it.val = val;
    cmd_queue.push_back(it);
  endtask

  // Input driver: presents queued commands at the falling edge with random gaps.
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || in_taken)) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        drv_item = cmd_queue.pop_front();
        s_tdata <= {7'd0, drv_item.val, drv_item.pos, drv_item.cmd};
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 49) == 0) in_quiet = ~in_quiet;
        in_gap = in_quiet ? 0 : pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output back-pressure: random stalls, with quiet stretches in between.
  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 199) == 0) out_quiet = ~out_quiet;
      if (out_stall > 0) begin
        out_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!out_quiet && $urandom_range(0, 99) < 20) out_stall = pick_gap();
      end
    end
  end

  // Monitor: predicts on accepted commands and checks every accepted result.
  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        list_apply(drv_item);
      end
      if (m_tvalid && m_tready) begin
        got = '{ok: m_tuser, value: m_tdata[31:0], fpos: m_tdata[35:32],
                len: m_tdata[40:36], last: m_tlast};
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("ERROR: unexpected result ok=%0b value=%h fpos=%0d len=%0d last=%0b",
                     got.ok, got.value, got.fpos, got.len, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got !== want || m_tdata[47:41] !== 7'd0) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("ERROR: expected ok=%0b value=%h fpos=%0d len=%0d last=%0b,",
                       want.ok, want.value, want.fpos, want.len, want.last,
                       " got ok=%0b value=%h fpos=%0d len=%0d last=%0b pad=%h",
                       got.ok, got.value, got.fpos, got.len, got.last, m_tdata[47:41]);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int n;
    int r;
    logic [3:0] cmd;
    logic [4:0] pos;
    logic [31:0] val;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    errors = 0;
    cycles = 0;
    in_gap = 0;
    out_stall = 0;
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    in_taken = 1'b0;
    list_len = 0;
    foreach (list_words[i]) list_words[i] = 32'd0;

    // A small pool of values makes repeated and searchable entries common.
    val_pool[0] = 32'h0000_0000;
    val_pool[1] = 32'hFFFF_FFFF;
    val_pool[2] = 32'h8000_0000;
    val_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 8; i++) val_pool[i] = $urandom();

    // Directed: empty list, extremes, edge positions, head and tail searches.
    add_cmd(CMD_TRAVERSE, 5'd0, 32'd0);
    add_cmd(CMD_GET_AT, 5'd0, 32'd0);
    add_cmd(CMD_DEL_AT, 5'd0, 32'd0);
    add_cmd(CMD_LOCATE, 5'd0, 32'h0000_0000);
    add_cmd(CMD_HEAD_INS, 5'd0, 32'h8000_0000);
    add_cmd(CMD_TAIL_INS, 5'd31, 32'h7FFF_FFFF);
    add_cmd(CMD_INS_AT, 5'd1, 32'hFFFF_FFFF);
    add_cmd(CMD_INS_AT, 5'd5, 32'h1234_5678);
    add_cmd(CMD_INS_AT, 5'd31, 32'h1234_5678);
    add_cmd(CMD_HEAD_INS, 5'd0, 32'h0000_0000);
    add_cmd(CMD_LOCATE, 5'd0, 32'hFFFF_FFFF);
    add_cmd(CMD_PRIOR, 5'd0, 32'h0000_0000);
    add_cmd(CMD_NEXT, 5'd0, 32'h7FFF_FFFF);
    add_cmd(CMD_PRIOR, 5'd0, 32'h7FFF_FFFF);
    add_cmd(CMD_NEXT, 5'd0, 32'h0000_0000);
    add_cmd(CMD_LOCATE, 5'd0, 32'h0000_3039);
    add_cmd(CMD_GET_AT, 5'd3, 32'd0);
    add_cmd(CMD_GET_AT, 5'd4, 32'd0);
    add_cmd(CMD_UNUSED_FIRST, 5'd0, 32'd0);
    add_cmd(CMD_UNUSED_LAST, 5'd31, 32'hFFFF_FFFF);
    add_cmd(CMD_TRAVERSE, 5'd0, 32'd0);
    add_cmd(CMD_DEL_AT, 5'd31, 32'd0);
    add_cmd(CMD_DEL_AT, 5'd1, 32'd0);
    add_cmd(CMD_CLEAR, 5'd0, 32'd0);
    add_cmd(CMD_TRAVERSE, 5'd0, 32'd0);

    // Random: insert-heavy so the list often fills, with searches on live values.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 15) cmd = CMD_HEAD_INS;
      else if (r < 30) cmd = CMD_TAIL_INS;
      else if (r < 44) cmd = CMD_INS_AT;
      else if (r < 56) cmd = CMD_DEL_AT;
      else if (r < 64) cmd = CMD_GET_AT;
      else if (r < 71) cmd = CMD_LOCATE;
      else if (r < 77) cmd = CMD_PRIOR;
      else if (r < 83) cmd = CMD_NEXT;
      else if (r < 86) cmd = CMD_CLEAR;
      else if (r < 95) cmd = CMD_TRAVERSE;
      else cmd = 4'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      pos = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 16))
                                         : 5'($urandom_range(0, 31));
      if (cmd == CMD_LOCATE || cmd == CMD_PRIOR || cmd == CMD_NEXT)
        val = ($urandom_range(0, 99) < 70) ? val_pool[$urandom_range(0, 7)] : $urandom();
      else
        val = ($urandom_range(0, 99) < 50) ? val_pool[$urandom_range(0, 7)] : $urandom();
      add_cmd(cmd, pos, val);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the last command to go in and for every result to come out.
    while (cmd_queue.size() > 0 || s_tvalid) @(posedge clk);
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
